// File: design/apc_pkg.sv
package apc_pkg;

    localparam int CNT_W     = 16;
    localparam int CFG_IDX_W = 1;
    localparam int IN_DATA_W  = 8;
    localparam int OUT_DATA_W = 8;

    localparam logic [CNT_W-1:0] BEEP_RELOAD_RST = 16'd100;
    localparam logic [CNT_W-1:0] SEND_RELOAD_RST = 16'd1000;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_BEEP_RELOAD = 1'b0,
        CFG_SEND_RELOAD = 1'b1
    } cfg_idx_t;

    // One input item.
    typedef struct packed {
        logic kind;
        logic red_pressed;
        logic green_pressed;
        logic blue_pressed;
        logic yellow_pressed;
    } item_t;

    // One result item, last field in the lowest bit.
    typedef struct packed {
        logic alert_active;
        logic send_request;
        logic buzzer_on;
        logic blue_led;
        logic green_led;
        logic yellow_led;
        logic red_led;
    } result_t;

    // Handshake between the input register and the result register.
    typedef struct packed {
        logic valid;
        logic advance;
    } stage_ctrl_t;

endpackage

// File: design/apc_in_reg.sv
module apc_in_reg (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_tvalid,
    output logic                       s_tready,
    input  apc_pkg::item_t             item_in,
    input  logic                       advance,
    output logic                       item_valid,
    output apc_pkg::item_t             item_out
);

    logic           valid_reg;
    apc_pkg::item_t item_reg;

    // Take a new item when empty or when the held one moves on this cycle.
    assign s_tready   = !valid_reg || advance;
    assign item_valid = valid_reg;
    assign item_out   = item_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (s_tready) begin
            valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            item_reg <= item_in;
        end
    end

endmodule

// File: design/apc_core.sv
module apc_core (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            fire,
    input  apc_pkg::item_t                  item,
    input  logic                            cfg_valid,
    input  logic [apc_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [apc_pkg::CNT_W-1:0]       cfg_data,
    output apc_pkg::result_t                res
);

    logic                      alert_reg, muted_reg, ymode_reg, phase_reg;
    logic                      red_reg, yel_reg, green_reg, blue_reg, buzz_reg;
    logic [apc_pkg::CNT_W-1:0] beep_cnt_reg, send_cnt_reg;
    logic [apc_pkg::CNT_W-1:0] beep_reload_reg, send_reload_reg;

    logic                      alert_next, muted_next, ymode_next, phase_next;
    logic                      red_next, yel_next, green_next, blue_next, buzz_next;
    logic [apc_pkg::CNT_W-1:0] beep_cnt_next, send_cnt_next;
    logic                      send_next;

    always_comb begin
        alert_next    = alert_reg;
        muted_next    = muted_reg;
        ymode_next    = ymode_reg;
        phase_next    = phase_reg;
        red_next      = red_reg;
        yel_next      = yel_reg;
        green_next    = green_reg;
        blue_next     = blue_reg;
        buzz_next     = buzz_reg;
        beep_cnt_next = beep_cnt_reg;
        send_cnt_next = send_cnt_reg;
        send_next     = 1'b0;

        if (item.kind) begin
            // Toggle: flip alert, clear modes; counters hold.
            alert_next = !alert_reg;
            muted_next = 1'b0;
            ymode_next = 1'b0;
            blue_next  = 1'b0;
            yel_next   = 1'b0;
            send_next  = 1'b1;
        end else begin
            if (item.red_pressed || item.green_pressed) begin
                alert_next = item.red_pressed;
                muted_next = 1'b0;
                ymode_next = 1'b0;
                blue_next  = 1'b0;
                yel_next   = 1'b0;
                send_next  = 1'b1;
            end else if (item.blue_pressed) begin
                blue_next  = 1'b1;
                muted_next = 1'b1;
            end else if (item.yellow_pressed) begin
                alert_next = 1'b0;
                muted_next = 1'b0;
                blue_next  = 1'b0;
                send_next  = 1'b1;
                green_next = 1'b0;
                yel_next   = 1'b1;
                ymode_next = 1'b1;
            end

            if (alert_next) begin
                if (beep_cnt_reg == '0) begin
                    beep_cnt_next = beep_reload_reg;
                    if (!phase_reg) begin
                        green_next = 1'b0;
                        red_next   = 1'b1;
                        if (!muted_next) begin
                            buzz_next = 1'b1;
                        end
                    end else begin
                        red_next  = 1'b0;
                        buzz_next = 1'b0;
                    end
                    phase_next = !phase_reg;
                end else begin
                    beep_cnt_next = beep_cnt_reg - 1'b1;
                end
            end else begin
                red_next  = 1'b0;
                buzz_next = 1'b0;
                if (!ymode_next) begin
                    green_next = 1'b1;
                end
            end

            if (send_cnt_reg == '0) begin
                send_cnt_next = send_reload_reg;
                send_next     = 1'b1;
            end else begin
                send_cnt_next = send_cnt_reg - 1'b1;
            end
        end
    end

    assign res.red_led      = red_next;
    assign res.yellow_led   = yel_next;
    assign res.green_led    = green_next;
    assign res.blue_led     = blue_next;
    assign res.buzzer_on    = buzz_next;
    assign res.send_request = send_next;
    assign res.alert_active = alert_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            alert_reg    <= 1'b0;
            muted_reg    <= 1'b0;
            ymode_reg    <= 1'b0;
            phase_reg    <= 1'b0;
            red_reg      <= 1'b0;
            yel_reg      <= 1'b0;
            green_reg    <= 1'b0;
            blue_reg     <= 1'b0;
            buzz_reg     <= 1'b0;
            beep_cnt_reg <= apc_pkg::BEEP_RELOAD_RST;
            send_cnt_reg <= apc_pkg::SEND_RELOAD_RST;
        end else if (fire) begin
            alert_reg    <= alert_next;
            muted_reg    <= muted_next;
            ymode_reg    <= ymode_next;
            phase_reg    <= phase_next;
            red_reg      <= red_next;
            yel_reg      <= yel_next;
            green_reg    <= green_next;
            blue_reg     <= blue_next;
            buzz_reg     <= buzz_next;
            beep_cnt_reg <= beep_cnt_next;
            send_cnt_reg <= send_cnt_next;
        end
    end

    // Reload values apply at the next countdown reload.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            beep_reload_reg <= apc_pkg::BEEP_RELOAD_RST;
            send_reload_reg <= apc_pkg::SEND_RELOAD_RST;
        end else if (cfg_valid) begin
            case (apc_pkg::cfg_idx_t'(cfg_index))
                apc_pkg::CFG_BEEP_RELOAD: beep_reload_reg <= cfg_data;
                apc_pkg::CFG_SEND_RELOAD: send_reload_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    a_buzz_needs_red: assert property (@(posedge aclk) disable iff (!aresetn)
        buzz_reg |-> red_reg)
        else $error("buzzer on while red LED is dark");

    a_green_yellow_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        !(green_reg && yel_reg))
        else $error("green and yellow LEDs lit together");

    a_yellow_tracks_mode: assert property (@(posedge aclk) disable iff (!aresetn)
        yel_reg == ymode_reg)
        else $error("yellow LED out of step with yellow mode");

    a_toggle_sends: assert property (@(posedge aclk) disable iff (!aresetn)
        fire && item.kind |=> send_cnt_reg == $past(send_cnt_reg))
        else $error("toggle event moved the send countdown");

endmodule

// File: design/apc_out_reg.sv
module apc_out_reg (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  apc_pkg::stage_ctrl_t               ctrl_in,
    output logic                               advance,
    input  apc_pkg::result_t                   res,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [apc_pkg::OUT_DATA_W-1:0]     m_tdata
);

    logic             valid_reg;
    apc_pkg::result_t res_reg;

    // Move on when the result slot is empty or is being drained.
    assign advance  = !valid_reg || m_tready;
    assign m_tvalid = valid_reg;
    assign m_tdata  = {{(apc_pkg::OUT_DATA_W - $bits(apc_pkg::result_t)){1'b0}}, res_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (advance) begin
            valid_reg <= ctrl_in.valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && ctrl_in.valid) begin
            res_reg <= res;
        end
    end

endmodule

// File: design/alarm_panel_controller_unit.sv
// Alarm panel controller.
// Input stream (s_*): one transfer per event. s_tuser is the kind (0 timer
// tick, 1 toggle button event); s_tdata carries the active-high button bits.
// Output stream (m_*): exactly one result transfer per input transfer, in
// order, with the LED and buzzer levels, the send request flag and the
// alert status after that event.
// Config channel (cfg_*): index 0 writes the beep reload, index 1 the send
// reload; always ready. Write only while no event is in flight; a new value
// takes effect at the next countdown reload.
// Path: an input transfer enters the input register, then the result
// register; m_tvalid rises once its result is in the result register.
// Throughput: one event per cycle while m_tready stays high, set by the
// state update between the two registers.
// Reset (aresetn low, synchronous): alert off, all LEDs dark, beep reload
// 100, send reload 1000, both countdowns loaded from those values.
// When the receiver stalls, the result holds in the output register; the
// input register still takes one more event, then s_tready drops until
// the output drains.
module alarm_panel_controller_unit (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // [0] red_pressed, [1] green_pressed, [2] blue_pressed, [3] yellow_pressed
    input  logic [apc_pkg::IN_DATA_W-1:0]     s_tdata,
    // [0] kind
    input  logic                              s_tuser,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // [0] red_led, [1] yellow_led, [2] green_led, [3] blue_led,
    // [4] buzzer_on, [5] send_request, [6] alert_active
    output logic [apc_pkg::OUT_DATA_W-1:0]    m_tdata,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [apc_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [apc_pkg::CNT_W-1:0]         cfg_data
);

    apc_pkg::item_t       item_in, item_q;
    apc_pkg::result_t     res;
    apc_pkg::stage_ctrl_t ctrl;
    logic                 item_valid, advance;

    // Unpack the input transfer into named fields.
    assign item_in.kind           = s_tuser;
    assign item_in.red_pressed    = s_tdata[0];
    assign item_in.green_pressed  = s_tdata[1];
    assign item_in.blue_pressed   = s_tdata[2];
    assign item_in.yellow_pressed = s_tdata[3];

    assign cfg_ready     = 1'b1;
    assign ctrl.valid    = item_valid;
    assign ctrl.advance  = advance;

    apc_in_reg u_in_reg (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .item_in    (item_in),
        .advance    (ctrl.advance),
        .item_valid (item_valid),
        .item_out   (item_q)
    );

    // Commit state exactly when the held event moves into the result register.
    apc_core u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .fire      (ctrl.valid && ctrl.advance),
        .item      (item_q),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .res       (res)
    );

    apc_out_reg u_out_reg (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ctrl_in  (ctrl),
        .advance  (advance),
        .res      (res),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

// File: tb/apc_panel_checker.sv
`timescale 1ns / 100ps
module apc_panel_checker (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    input  logic                              s_tready,
    input  logic [apc_pkg::IN_DATA_W-1:0]     s_tdata,
    input  logic                              s_tuser,
    input  logic                              m_tvalid,
    input  logic                              m_tready,
    input  logic [apc_pkg::OUT_DATA_W-1:0]    m_tdata,
    input  logic                              cfg_valid,
    input  logic                              cfg_ready,
    input  logic [apc_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [apc_pkg::CNT_W-1:0]         cfg_data,
    output int                                failures,
    output int                                results_pending
);

    // Panel model state
    logic [apc_pkg::CNT_W-1:0] beep_reload_val;
    logic [apc_pkg::CNT_W-1:0] send_reload_val;
    logic                      alert_on;
    logic                      muted;
    logic                      yellow_mode;
    logic                      beep_phase;
    logic [apc_pkg::CNT_W-1:0] beep_count;
    logic [apc_pkg::CNT_W:0]   send_count;
    logic                      send_req;
    apc_pkg::result_t          lamps;

    apc_pkg::result_t expected_panel_q [$];

    function automatic string field_name(input int idx);
        case (idx)
            0:       return "red_led";
            1:       return "yellow_led";
            2:       return "green_led";
            3:       return "blue_led";
            4:       return "buzzer_on";
            5:       return "send_request";
            default: return "alert_active";
        endcase
    endfunction

    task automatic switch_alert(input logic on);
        alert_on         = on;
        muted            = 1'b0;
        yellow_mode      = 1'b0;
        lamps.blue_led   = 1'b0;
        lamps.yellow_led = 1'b0;
        send_req         = 1'b1;
    endtask

    task automatic advance_panel(input apc_pkg::item_t evt,
                                 output apc_pkg::result_t panel);
        send_req = 1'b0;
        if (evt.kind) begin
            switch_alert(!alert_on);
        end else begin
            if (evt.red_pressed) begin
                switch_alert(1'b1);
            end else if (evt.green_pressed) begin
                switch_alert(1'b0);
            end else if (evt.blue_pressed) begin
                lamps.blue_led = 1'b1;
                muted          = 1'b1;
            end else if (evt.yellow_pressed) begin
                switch_alert(1'b0);
                lamps.green_led  = 1'b0;
                lamps.yellow_led = 1'b1;
                yellow_mode      = 1'b1;
            end

            // beep phase runs only while the alert is on
            if (alert_on) begin
                if (beep_count == '0) begin
                    beep_count = beep_reload_val;
                    if (!beep_phase) begin
                        lamps.green_led = 1'b0;
                        lamps.red_led   = 1'b1;
                        if (!muted)
                            lamps.buzzer_on = 1'b1;
                    end else begin
                        lamps.red_led   = 1'b0;
                        lamps.buzzer_on = 1'b0;
                    end
                    beep_phase = !beep_phase;
                end else begin
                    beep_count = beep_count - 1'b1;
                end
            end else begin
                lamps.red_led   = 1'b0;
                lamps.buzzer_on = 1'b0;
                if (!yellow_mode)
                    lamps.green_led = 1'b1;
            end

            if (send_count == '0) begin
                send_count = {1'b0, send_reload_val};
                send_req   = 1'b1;
            end else begin
                send_count = send_count - 1'b1;
            end
        end
        panel              = lamps;
        panel.send_request = send_req;
        panel.alert_active = alert_on;
    endtask

    task automatic check_result(input apc_pkg::result_t want, input apc_pkg::result_t got);
        if (got !== want) begin
            failures++;
            for (int i = 0; i < $bits(apc_pkg::result_t); i++) begin
                if (got[i] !== want[i])
                    $display("%0t: %s mismatch, expected %0b, got %0b",
                             $time, field_name(i), want[i], got[i]);
            end
        end
    endtask

    always @(posedge aclk) begin
        apc_pkg::item_t   evt;
        apc_pkg::result_t want;
        apc_pkg::result_t got;
        if (!aresetn) begin
            beep_reload_val = apc_pkg::BEEP_RELOAD_RST;
            send_reload_val = apc_pkg::SEND_RELOAD_RST;
            alert_on        = 1'b0;
            muted           = 1'b0;
            yellow_mode     = 1'b0;
            beep_phase      = 1'b0;
            beep_count      = apc_pkg::BEEP_RELOAD_RST;
            send_count      = {1'b0, apc_pkg::SEND_RELOAD_RST};
            send_req        = 1'b0;
            lamps           = '0;
            failures        = 0;
            expected_panel_q.delete();
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (apc_pkg::cfg_idx_t'(cfg_index))
                    apc_pkg::CFG_BEEP_RELOAD: beep_reload_val = cfg_data;
                    apc_pkg::CFG_SEND_RELOAD: send_reload_val = cfg_data;
                    default: ;
                endcase
            end
            if (m_tvalid && m_tready) begin
                got = m_tdata[$bits(apc_pkg::result_t)-1:0];
                if (expected_panel_q.size() == 0) begin
                    failures++;
                    $display("%0t: result with none expected, expected none, got %b",
                             $time, got);
                end else begin
                    want = expected_panel_q.pop_front();
                    check_result(want, got);
                end
            end
            if (s_tvalid && s_tready) begin
                evt.kind           = s_tuser;
                evt.red_pressed    = s_tdata[0];
                evt.green_pressed  = s_tdata[1];
                evt.blue_pressed   = s_tdata[2];
                evt.yellow_pressed = s_tdata[3];
                advance_panel(evt, want);
                expected_panel_q.push_back(want);
            end
        end
        results_pending = expected_panel_q.size();
    end

endmodule

// File: tb/tb_alarm_panel_controller_unit.sv
`timescale 1ns / 100ps
module tb_alarm_panel_controller_unit;

    localparam int CLK_PERIOD      = 12;
    localparam int RESET_CYCLES    = 10;
    localparam int IDLE_LIMIT      = 2000;  // cycles without any transfer
    localparam int SETTLE_CYCLES   = 8;     // covers the two-stage latency
    localparam int PHASES          = 6;
    localparam int PHASE_ITEMS     = 100;
    localparam int HOLD_OFF_CYCLES = 60;

    localparam logic KIND_TICK   = 1'b0;
    localparam logic KIND_TOGGLE = 1'b1;

    // button bits as they sit in s_tdata: [0] red, [1] green, [2] blue, [3] yellow
    localparam logic [3:0] BTN_NONE   = 4'b0000;
    localparam logic [3:0] BTN_RED    = 4'b0001;
    localparam logic [3:0] BTN_GREEN  = 4'b0010;
    localparam logic [3:0] BTN_BLUE   = 4'b0100;
    localparam logic [3:0] BTN_YELLOW = 4'b1000;
    localparam logic [3:0] BTN_ALL    = 4'b1111;

    logic                           aclk;
    logic                           aresetn;
    logic                           s_tvalid;
    logic                           s_tready;
    logic [apc_pkg::IN_DATA_W-1:0]  s_tdata;
    logic                           s_tuser;
    logic                           m_tvalid;
    logic                           m_tready;
    logic [apc_pkg::OUT_DATA_W-1:0] m_tdata;
    logic                           cfg_valid;
    logic                           cfg_ready;
    logic [apc_pkg::CFG_IDX_W-1:0]  cfg_index;
    logic [apc_pkg::CNT_W-1:0]      cfg_data;

    int failures;
    int results_pending;

    // Idling controls for the sender and the receiver process
    bit tx_gaps_on;
    bit rx_gaps_on;
    int rx_hold_cycles;

    alarm_panel_controller_unit u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    apc_panel_checker u_checker (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .s_tdata         (s_tdata),
        .s_tuser         (s_tuser),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_tdata         (m_tdata),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .failures        (failures),
        .results_pending (results_pending)
    );

    initial begin
        aclk = 1'b0;
        forever #(CLK_PERIOD / 2) aclk = ~aclk;
    end

    // Offer one event and hold it until the transfer happens. Enter and leave
    // at a falling edge; s_tvalid is left high so back-to-back events flow.
    task automatic send_event(input logic kind, input logic [3:0] buttons);
        int gap;
        if (tx_gaps_on && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 5);
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= {4'b0000, buttons};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        @(negedge aclk);
    endtask

    // Weighted mix: mostly plain ticks so the beep and send counters run,
    // with single buttons to walk the alert through its states, some
    // multi-button ticks for priority, and toggle events with junk buttons.
    task automatic send_random_event;
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 60)
            send_event(KIND_TICK, BTN_NONE);
        else if (pick < 68)
            send_event(KIND_TICK, BTN_RED);
        else if (pick < 73)
            send_event(KIND_TICK, BTN_GREEN);
        else if (pick < 80)
            send_event(KIND_TICK, BTN_BLUE);
        else if (pick < 85)
            send_event(KIND_TICK, BTN_YELLOW);
        else if (pick < 93)
            send_event(KIND_TICK, 4'($urandom_range(0, 15)));
        else
            send_event(KIND_TOGGLE, 4'($urandom_range(0, 15)));
    endtask

    task automatic wait_results_drained;
        while (results_pending != 0) @(negedge aclk);
    endtask

    // Write a register only with the pipeline empty: drop the input valid,
    // drain, let the last event leave both stages, then do the transfer.
    task automatic write_register(input apc_pkg::cfg_idx_t idx,
                                  input logic [apc_pkg::CNT_W-1:0] value);
        s_tvalid <= 1'b0;
        wait_results_drained();
        repeat (SETTLE_CYCLES) @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // Receiver: random short stalls, or one long hold-off when requested
    initial begin
        int stall;
        forever begin
            @(negedge aclk);
            if (rx_hold_cycles > 0) begin
                stall          = rx_hold_cycles;
                rx_hold_cycles = 0;
            end else if (rx_gaps_on && $urandom_range(0, 3) == 0) begin
                stall = $urandom_range(1, 5);
            end else begin
                stall = 0;
            end
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(negedge aclk);
            end
            m_tready <= 1'b1;
        end
    end

    // Watchdog: end the run if no transfer of any kind happens for too long
    initial begin
        int idle_cycles;
        idle_cycles = 0;
        @(posedge aresetn);
        while (idle_cycles < IDLE_LIMIT) begin
            @(posedge aclk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) ||
                (cfg_valid && cfg_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("FAIL");
        $finish;
    end

    initial begin
        logic [apc_pkg::CNT_W-1:0] beep_val;
        logic [apc_pkg::CNT_W-1:0] send_val;

        // Drive every input to a known level and hold reset
        aresetn        <= 1'b0;
        s_tvalid       <= 1'b0;
        s_tdata        <= '0;
        s_tuser        <= KIND_TICK;
        m_tready       <= 1'b0;
        cfg_valid      <= 1'b0;
        cfg_index      <= apc_pkg::CFG_BEEP_RELOAD;
        cfg_data       <= '0;
        tx_gaps_on     = 1'b1;
        rx_gaps_on     = 1'b1;
        rx_hold_cycles = 0;
        repeat (RESET_CYCLES) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Reset reloads: alert comes on, no flip for a long while
        send_event(KIND_TICK, BTN_NONE);
        send_event(KIND_TICK, BTN_RED);

        // Fastest beep, short send period for the directed part
        write_register(apc_pkg::CFG_BEEP_RELOAD, 16'd0);
        write_register(apc_pkg::CFG_SEND_RELOAD, 16'd3);

        send_event(KIND_TICK, BTN_NONE);
        send_event(KIND_TICK, BTN_NONE);
        // mute while the alert is on, before the beep countdown first flips
        send_event(KIND_TICK, BTN_BLUE);
        send_event(KIND_TICK, BTN_NONE);
        send_event(KIND_TICK, BTN_NONE);
        // red wins over all others and clears mute
        send_event(KIND_TICK, BTN_ALL);
        send_event(KIND_TICK, BTN_NONE);
        // green wins over blue and yellow
        send_event(KIND_TICK, BTN_GREEN | BTN_BLUE | BTN_YELLOW);
        // blue wins over yellow with the alert off
        send_event(KIND_TICK, BTN_BLUE | BTN_YELLOW);
        send_event(KIND_TICK, BTN_YELLOW);
        send_event(KIND_TICK, BTN_NONE);
        // toggle ignores the buttons and skips the counters
        send_event(KIND_TOGGLE, BTN_ALL);
        send_event(KIND_TICK, BTN_NONE);
        send_event(KIND_TICK, BTN_NONE);
        send_event(KIND_TOGGLE, BTN_NONE);
        send_event(KIND_TICK, BTN_NONE);
        send_event(KIND_TICK, BTN_RED | BTN_GREEN);
        send_event(KIND_TICK, BTN_NONE);
        // yellow while the alert is on disables it
        send_event(KIND_TICK, BTN_YELLOW);
        send_event(KIND_TICK, BTN_GREEN);
        send_event(KIND_TOGGLE, BTN_NONE);

        for (int ph = 0; ph < PHASES; ph++) begin
            case (ph)
                0: begin
                    beep_val = '0;
                    send_val = '0;
                end
                1: begin
                    beep_val = '1;
                    send_val = '1;
                end
                2: begin
                    beep_val = 16'd1;
                    send_val = 16'd4;
                end
                4: begin
                    beep_val = 16'd2;
                    send_val = 16'd7;
                end
                default: begin
                    beep_val = apc_pkg::CNT_W'($urandom_range(0, 6));
                    send_val = apc_pkg::CNT_W'($urandom_range(0, 30));
                end
            endcase
            // last phase runs flat out on both sides
            if (ph == PHASES - 1) begin
                tx_gaps_on = 1'b0;
                rx_gaps_on = 1'b0;
            end
            write_register(apc_pkg::CFG_BEEP_RELOAD, beep_val);
            write_register(apc_pkg::CFG_SEND_RELOAD, send_val);

            // long receiver hold-off while events keep coming: fill and stall
            if (ph == 2)
                rx_hold_cycles = HOLD_OFF_CYCLES;

            for (int i = 0; i < PHASE_ITEMS; i++) begin
                // pause the sender until every result is back
                if (ph == 3 && i == PHASE_ITEMS / 2) begin
                    s_tvalid <= 1'b0;
                    @(negedge aclk);
                    wait_results_drained();
                end
                send_random_event();
            end
        end

        s_tvalid <= 1'b0;
        wait_results_drained();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (failures == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
